// File: sv/sha512_pkg.sv
// ----------------------------------------------------------------------------
// SHA-512 / SHA-384 package
// Round constants, initial values and the sequencer state type.
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam int Rounds = 80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  function automatic logic [63:0] round_k(input logic [6:0] i);
    logic [63:0] k;
    unique case (i)
      7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] init_value(input logic mode, input logic [2:0] i);
    logic [63:0] v;
    unique case ({mode, i})
      4'd0: v = 64'h6a09e667f3bcc908; 4'd1: v = 64'hbb67ae8584caa73b;
      4'd2: v = 64'h3c6ef372fe94f82b; 4'd3: v = 64'ha54ff53a5f1d36f1;
      4'd4: v = 64'h510e527fade682d1; 4'd5: v = 64'h9b05688c2b3e6c1f;
      4'd6: v = 64'h1f83d9abfb41bd6b; 4'd7: v = 64'h5be0cd19137e2179;
      4'd8: v = 64'hcbbb9d5dc1059ed8; 4'd9: v = 64'h629a292a367cd507;
      4'd10: v = 64'h9159015a3070dd17; 4'd11: v = 64'h152fecd8f70e5939;
      4'd12: v = 64'h67332667ffc00b31; 4'd13: v = 64'h8eb44a8768581511;
      4'd14: v = 64'hdb0c2e0d64f98fa7; 4'd15: v = 64'h47b5481dbefa4fa4;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

// File: sv/sha512_round.sv
// ----------------------------------------------------------------------------
// SHA-512 round unit
// One compression round and one message schedule step, shared by all rounds.
// ----------------------------------------------------------------------------
module sha512_round (
  input  logic [7:0][63:0] v,
  input  logic [15:0][63:0] w,
  input  logic [63:0]       k,
  output logic [7:0][63:0] v_next,
  output logic [63:0]       w_new
);
  import sha512_pkg::*;

  logic [63:0] e, a, t1, t2, x, y, s0, s1;

  // Working variable update.
  always_comb begin
    e  = v[4];
    a  = v[0];
    t1 = v[7] + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41))
       + ((e & v[5]) ^ (~e & v[6])) + k + w[0];
    t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39))
       + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
    v_next[7] = v[6];
    v_next[6] = v[5];
    v_next[5] = e;
    v_next[4] = v[3] + t1;
    v_next[3] = v[2];
    v_next[2] = v[1];
    v_next[1] = a;
    v_next[0] = t1 + t2;
  end

  // Schedule word sixteen steps ahead; w[0] is the word of this round.
  always_comb begin
    x     = w[1];
    y     = w[14];
    s0    = ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
    s1    = ror64(y, 19) ^ ror64(y, 61) ^ (y >> 6);
    w_new = s1 + w[9] + s0 + w[0];
  end

endmodule

// File: sv/sha512_sha384_hasher.sv
// ----------------------------------------------------------------------------
// SHA-512 / SHA-384 hasher
// Takes big-endian message words, pads the last one and emits the digest.
// ----------------------------------------------------------------------------
// Channel  | Dir | Content
// s_axis   | in  | tdata = data_word[63:0], valid_bytes[67:64]; tlast = last_item
// m_axis   | out | tdata = digest_word[63:0], word_index[66:64]; tlast = last_word
// cfg      | in  | cfg_we/cfg_wdata = hash_mode
//
// A word that does not close a block is only stored and the hasher stays
// ready; a word that closes one first runs the rounds in the shared round
// unit and a fold. The last word adds a padding step plus one or two blocks,
// then 6 or 8 output words, each held until m_axis_tready. Reset loads the
// SHA-512 initial values and clears the byte count. No new word is taken
// until the current one, including its digest, is done.
module sha512_sha384_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // data_word[63:0], valid_bytes[67:64], zero
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // digest_word[63:0], word_index[66:64], zero
  output logic        m_axis_tlast
);
  import sha512_pkg::*;

  state_t state, state_next;
  logic             hash_mode;
  logic [7:0][63:0] chain;
  logic [7:0][63:0] v;
  logic [15:0][63:0] w;
  logic [63:0]      msg_bytes;
  logic [6:0]       round;
  logic [2:0]       out_idx;
  logic             final_blk;  // padding is done, this block ends the message
  logic             second_blk; // padding needs another block after this one
  logic             s_last_pend;
  logic [7:0][63:0] v_rnd;
  logic [63:0]      w_new;

  logic        acc;
  logic [63:0] din;
  logic [3:0]  nb;
  logic [3:0]  slot;
  logic [6:0]  off;
  logic [63:0] mask;
  logic [2:0]  n_last;

  sha512_round u_round (
    .v      (v),
    .w      (w),
    .k      (round_k(round)),
    .v_next (v_rnd),
    .w_new  (w_new)
  );

  assign acc    = s_axis_tvalid && s_axis_tready;
  assign din    = s_axis_tdata[63:0];
  assign nb     = (s_axis_tdata[67:64] > 4'd8) ? 4'd8 : s_axis_tdata[67:64];
  assign slot   = msg_bytes[6:3];
  assign off    = msg_bytes[6:0];
  assign mask   = (nb == 4'd0) ? 64'd0 : ~64'd0 << (7'd64 - {nb, 3'b000});
  assign n_last = hash_mode ? 3'd5 : 3'd7;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (s_axis_tlast) begin
            if (nb != 4'd0 && msg_bytes[6:0] + {3'd0, nb} == 7'd0 &&
                msg_bytes[6:0] != 7'd0)
              state_next = ST_ROUND;
            else if (nb != 4'd0 && {1'b0, msg_bytes[6:0]} + {4'd0, nb} == 8'd128)
              state_next = ST_ROUND;
            else
              state_next = ST_PAD;
          end else if (slot == 4'd15) begin
            state_next = ST_ROUND;
          end
        end
      end
      ST_PAD:   state_next = ST_ROUND;
      ST_ROUND: if (round == 7'(Rounds - 1)) state_next = ST_FOLD;
      ST_FOLD: begin
        if (final_blk) state_next = ST_EMIT;
        else if (second_blk) state_next = ST_ROUND;
        else if (s_last_pend) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_EMIT:  if (m_axis_tready && out_idx == n_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_EMIT);
    m_axis_tdata  = {5'd0, out_idx, chain[out_idx]};
    m_axis_tlast  = (out_idx == n_last);
  end

  // Datapath and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hash_mode  <= 1'b0;
      msg_bytes  <= '0;
      round      <= '0;
      out_idx    <= '0;
      final_blk  <= 1'b0;
      second_blk <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= init_value(1'b0, 3'(i));
    end else begin
      state <= state_next;
      if (cfg_we) begin
        hash_mode <= cfg_wdata;
        msg_bytes <= '0;
        for (int i = 0; i < 8; i++) chain[i] <= init_value(cfg_wdata, 3'(i));
      end
      unique case (state)
        ST_IDLE: begin
          out_idx <= '0;
          if (acc) begin
            final_blk  <= 1'b0;
            second_blk <= 1'b0;
            round      <= '0;
            v          <= chain;
            if (!s_axis_tlast) begin
              w[slot]   <= din;
              msg_bytes <= msg_bytes + 64'd8;
            end else begin
              if (nb != 4'd0) w[slot] <= din & mask;
              msg_bytes <= msg_bytes + {60'd0, nb};
            end
          end
        end
        ST_PAD: begin
          // Place 0x80 after the last byte, zero the rest, add the length
          // when it fits in this block.
          for (int i = 0; i < 16; i++) begin
            if (4'(i) == off[6:3]) begin
              if (off[2:0] == 3'd0) w[i] <= 64'h80 << 56;
              else w[i] <= w[i] | (64'h80 << (7'd56 - {1'b0, off[2:0], 3'b000}));
            end else if (i == 15 && off[6:3] < 4'd14) begin
              w[i] <= msg_bytes << 3;
            end else if (4'(i) > off[6:3]) begin
              w[i] <= '0;
            end
          end
          if (off[6:3] >= 4'd14) second_blk <= 1'b1;
          else final_blk <= 1'b1;
          v     <= chain;
          round <= '0;
        end
        ST_ROUND: begin
          v <= v_rnd;
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= w_new;
          round <= round + 7'd1;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
          for (int i = 0; i < 8; i++) v[i] <= chain[i] + v[i];
          round <= '0;
          if (second_blk) begin
            // Length-only block follows.
            for (int i = 0; i < 14; i++) w[i] <= '0;
            w[14]      <= '0;
            w[15]      <= msg_bytes << 3;
            second_blk <= 1'b0;
            final_blk  <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (m_axis_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == n_last) begin
              msg_bytes <= '0;
              for (int i = 0; i < 8; i++) chain[i] <= init_value(hash_mode, 3'(i));
            end
          end
        end
        default: ;
      endcase
    end
  end

  // A full last word closing a block still owes its padding block.
  always_ff @(posedge clk) begin
    if (rst) s_last_pend <= 1'b0;
    else if (acc) s_last_pend <= s_axis_tlast;
    else if (state == ST_PAD) s_last_pend <= 1'b0;
  end

endmodule

// File: sv/sha512_sha384_hasher_chk.sv
// ----------------------------------------------------------------------------
// SHA-512 / SHA-384 port checker
// Watches the ports of the hasher and is bound to it.
// ----------------------------------------------------------------------------
module sha512_sha384_hasher_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  // The input side never accepts while a digest is on offer.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while emitting");

  // Digest words count up by one after each taken word but the last.
  a_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tdata[66:64] == $past(m_axis_tdata[66:64]) + 3'd1)
    else $error("word index skipped");

  // The final word is index 5 or 7.
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      (m_axis_tdata[66:64] == 3'd5 || m_axis_tdata[66:64] == 3'd7))
    else $error("bad final index");

  // A stalled digest word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("digest dropped");

endmodule

bind sha512_sha384_hasher sha512_sha384_hasher_chk u_chk (.*);
